// ===== hdl/vss_pkg.sv =====
`default_nettype none

package vss_pkg;

    // vent motion phase codes
    localparam logic [1:0] PH_STOP  = 2'd0;
    localparam logic [1:0] PH_OPEN  = 2'd1;
    localparam logic [1:0] PH_CLOSE = 2'd2;

    // vent indexes
    localparam logic [1:0] VENT_LEFT   = 2'd0;
    localparam logic [1:0] VENT_RIGHT  = 2'd1;
    localparam logic [1:0] VENT_INTAKE = 2'd2;
    localparam int unsigned NUM_VENTS  = 3;

    // sequence steps
    localparam logic [3:0] STEP_IDLE         = 4'd0;
    localparam logic [3:0] STEP_OPEN_LEFT    = 4'd1;
    localparam logic [3:0] STEP_OPEN_RIGHT   = 4'd2;
    localparam logic [3:0] STEP_OPEN_INTAKE  = 4'd3;
    localparam logic [3:0] STEP_FAN_RUN      = 4'd4;
    localparam logic [3:0] STEP_FAN_STOP     = 4'd5;
    localparam logic [3:0] STEP_CLOSE_INTAKE = 4'd6;
    localparam logic [3:0] STEP_CLOSE_RIGHT  = 4'd7;
    localparam logic [3:0] STEP_CLOSE_LEFT   = 4'd8;
    localparam logic [3:0] STEP_CLOSED_WAIT  = 4'd9;

    // input item kinds
    localparam logic CMD_SAMPLE     = 1'b0;
    localparam logic CMD_POWER_FAIL = 1'b1;

    // register indexes
    localparam logic [2:0] CFG_SETPOINT      = 3'd0;
    localparam logic [2:0] CFG_INSIDE_DELTA  = 3'd1;
    localparam logic [2:0] CFG_OUTSIDE_DELTA = 3'd2;
    localparam logic [2:0] CFG_FROST_LIMIT   = 3'd3;
    localparam logic [2:0] CFG_FROST_DELTA   = 3'd4;
    localparam logic [2:0] CFG_TRAVEL_TIME   = 3'd5;
    localparam logic [2:0] CFG_AUTO_MODE     = 3'd6;

    localparam int unsigned CFG_DATA_W = 20;
    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 16;

    typedef struct packed {
        logic signed [11:0] setpoint;
        logic        [9:0]  inside_delta;
        logic        [9:0]  outside_delta;
        logic signed [11:0] frost_limit;
        logic        [9:0]  frost_delta;
        logic        [19:0] travel_ms;
        logic               auto_mode;
    } t_vss_cfg;

    typedef struct packed {
        logic [3:0]       step;
        logic             power;
        logic             fan;
        logic [2:0][1:0]  phase;
        logic [2:0][31:0] start_ms;
    } t_vss_state;

endpackage

`default_nettype wire

// ===== hdl/vss_step_logic.sv =====
`default_nettype none

module vss_step_logic (
    input  wire vss_pkg::t_vss_cfg   i_cfg,
    input  wire vss_pkg::t_vss_state i_state,
    input  wire logic                i_cmd,
    input  wire logic signed [11:0]  i_outside_temp,
    input  wire logic signed [11:0]  i_inside_temp,
    input  wire logic [31:0]         i_now_ms,
    output vss_pkg::t_vss_state      o_state
);
    import vss_pkg::*;

    logic signed [13:0] w_set;
    logic signed [13:0] w_frost;
    logic signed [13:0] w_out;
    logic signed [13:0] w_in_hi;
    logic signed [13:0] w_in_lo;
    logic signed [13:0] w_out_hi;
    logic signed [13:0] w_frost_lo;
    logic               w_stop;
    logic               w_start;
    logic [2:0]         w_expired;
    t_vss_state         w_nxt;

    // q10.4 sums, sign extended by two bits so they stay exact
    assign w_set      = {{2{i_cfg.setpoint[11]}}, i_cfg.setpoint};
    assign w_frost    = {{2{i_cfg.frost_limit[11]}}, i_cfg.frost_limit};
    assign w_out      = {{2{i_outside_temp[11]}}, i_outside_temp};
    assign w_in_hi    = {{2{i_inside_temp[11]}}, i_inside_temp}
                      + $signed({4'd0, i_cfg.inside_delta});
    assign w_in_lo    = {{2{i_inside_temp[11]}}, i_inside_temp}
                      - $signed({4'd0, i_cfg.inside_delta});
    assign w_out_hi   = w_out + $signed({4'd0, i_cfg.outside_delta});
    assign w_frost_lo = w_frost - $signed({4'd0, i_cfg.frost_delta});

    assign w_stop  = (w_set > w_in_hi) || (w_out_hi > w_in_hi) || (w_frost_lo > w_out);
    assign w_start = (w_set < w_in_lo) && (w_frost < w_out) && (w_out_hi < w_in_lo)
                   && i_state.power;

    // a vent is touched at most once per item after a reload, so the
    // registered start times are enough for the timeout check
    always_comb begin
        for (int v = 0; v < NUM_VENTS; v++) begin
            w_expired[v] = (i_now_ms - i_state.start_ms[v]) > {12'd0, i_cfg.travel_ms};
        end
    end

    always_comb begin
        w_nxt = i_state;
        if (i_cmd == CMD_POWER_FAIL) begin
            if (w_nxt.step != STEP_IDLE) begin
                w_nxt.power = 1'b0;
                w_nxt.step  = STEP_FAN_STOP;
            end
        end else if (i_cfg.auto_mode) begin
            if (w_nxt.step == STEP_IDLE && w_start) begin
                w_nxt.step = STEP_OPEN_LEFT;
            end
            if (w_nxt.step == STEP_OPEN_LEFT) begin
                if (w_nxt.phase[VENT_LEFT] == PH_OPEN) begin
                    if (w_expired[VENT_LEFT]) begin
                        w_nxt.phase[VENT_LEFT] = PH_STOP;
                        w_nxt.step             = STEP_OPEN_RIGHT;
                    end
                    if (w_stop) begin
                        w_nxt.phase[VENT_LEFT] = PH_STOP;
                        w_nxt.step             = STEP_CLOSE_LEFT;
                    end
                end else begin
                    w_nxt.phase[VENT_LEFT]    = PH_OPEN;
                    w_nxt.start_ms[VENT_LEFT] = i_now_ms;
                end
            end
            if (w_nxt.step == STEP_OPEN_RIGHT) begin
                if (w_nxt.phase[VENT_RIGHT] == PH_OPEN) begin
                    if (w_expired[VENT_RIGHT]) begin
                        w_nxt.phase[VENT_RIGHT] = PH_STOP;
                        w_nxt.step              = STEP_OPEN_INTAKE;
                    end
                end else begin
                    w_nxt.phase[VENT_RIGHT]    = PH_OPEN;
                    w_nxt.start_ms[VENT_RIGHT] = i_now_ms;
                end
            end
            if (w_nxt.step == STEP_OPEN_INTAKE) begin
                if (w_nxt.phase[VENT_INTAKE] == PH_OPEN) begin
                    if (w_expired[VENT_INTAKE]) begin
                        w_nxt.phase[VENT_INTAKE] = PH_STOP;
                        w_nxt.step               = STEP_FAN_RUN;
                    end
                end else begin
                    w_nxt.phase[VENT_INTAKE]    = PH_OPEN;
                    w_nxt.start_ms[VENT_INTAKE] = i_now_ms;
                end
            end
            if (w_nxt.step == STEP_FAN_RUN) begin
                if (w_nxt.fan) begin
                    if (w_stop) begin
                        w_nxt.step = STEP_FAN_STOP;
                    end
                end else begin
                    w_nxt.fan = 1'b1;
                end
            end
            if (w_nxt.step == STEP_FAN_STOP) begin
                w_nxt.fan  = 1'b0;
                w_nxt.step = STEP_CLOSE_INTAKE;
            end
            if (w_nxt.step == STEP_CLOSE_INTAKE) begin
                if (w_nxt.phase[VENT_INTAKE] == PH_CLOSE) begin
                    if (w_expired[VENT_INTAKE]) begin
                        w_nxt.phase[VENT_INTAKE] = PH_STOP;
                        w_nxt.step               = STEP_CLOSE_RIGHT;
                    end
                end else begin
                    w_nxt.phase[VENT_INTAKE]    = PH_CLOSE;
                    w_nxt.start_ms[VENT_INTAKE] = i_now_ms;
                end
            end
            if (w_nxt.step == STEP_CLOSE_RIGHT) begin
                if (w_nxt.phase[VENT_RIGHT] == PH_CLOSE) begin
                    if (w_expired[VENT_RIGHT]) begin
                        w_nxt.phase[VENT_RIGHT] = PH_STOP;
                        w_nxt.step              = STEP_CLOSE_LEFT;
                    end
                end else begin
                    w_nxt.phase[VENT_RIGHT]    = PH_CLOSE;
                    w_nxt.start_ms[VENT_RIGHT] = i_now_ms;
                end
            end
            if (w_nxt.step == STEP_CLOSE_LEFT) begin
                // left may have been stopped earlier in this item, then it reloads
                if (w_nxt.phase[VENT_LEFT] == PH_CLOSE) begin
                    if (w_expired[VENT_LEFT]) begin
                        w_nxt.phase[VENT_LEFT] = PH_STOP;
                        w_nxt.step             = STEP_CLOSED_WAIT;
                    end
                end else begin
                    w_nxt.phase[VENT_LEFT]    = PH_CLOSE;
                    w_nxt.start_ms[VENT_LEFT] = i_now_ms;
                end
            end
            if (w_nxt.step == STEP_CLOSED_WAIT && w_nxt.power) begin
                w_nxt.step = STEP_IDLE;
            end
        end else begin
            // manual mode: only end motions that ran out
            for (int v = 0; v < NUM_VENTS; v++) begin
                if ((i_state.phase[v] == PH_OPEN || i_state.phase[v] == PH_CLOSE)
                        && w_expired[v]) begin
                    w_nxt.phase[v] = PH_STOP;
                end
            end
        end
    end

    assign o_state = w_nxt;

endmodule

`default_nettype wire

// ===== hdl/ventilation_section_sequencer.sv =====
// ventilation section sequencer
// slave stream: one beat per sample or power-fail event; tuser is the kind
// (0 sample, 1 power failure), tdata carries outside temp, inside temp and
// the millisecond time stamp. master stream: one beat per accepted input
// beat with the fan and vent motor drives, the sequence step and power_ok.
// config: plain write port, register index on i_cfg_addr, written at any
// edge with i_cfg_we high; write only while no beat is in flight.
// output: the result beat is valid in the cycle after the input beat is taken.
// throughput: one beat per cycle while the result side does not stall; the
// whole step chain is evaluated by one combinational pass from the state
// registers into the state and result registers, with no register between.
// stall: the result register holds its beat while m_axis_tready is low and
// the input side keeps accepting as long as the result register is empty or
// is being drained in the same cycle.
// reset (synchronous, active low): config registers to documented values,
// step idle, power present, fan off, all vents stopped, no result pending.
`default_nettype none

module ventilation_section_sequencer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // config write port
    input  wire logic                              i_cfg_we,
    input  wire logic [2:0]                        i_cfg_addr,
    input  wire logic [vss_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: outside_temp[11:0], inside_temp[23:12], now_ms[55:24]
    input  wire logic [vss_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: cmd[0]
    input  wire logic                              s_axis_tuser,
    // result stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tdata: fan_on[0], left_open_drive[1], left_close_drive[2],
    // right_open_drive[3], right_close_drive[4], intake_open_drive[5],
    // intake_close_drive[6], sequence_step[10:7], power_ok[11], zero[15:12]
    output logic [vss_pkg::OUT_DATA_W-1:0]         m_axis_tdata
);
    import vss_pkg::*;

    t_vss_cfg   r_cfg;
    t_vss_state r_state;
    t_vss_state n_state;
    logic       r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic [OUT_DATA_W-1:0] n_m_data;
    logic       w_accept;

    // taking a beat whenever the result slot is free or drains this cycle
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    vss_step_logic u_step (
        .i_cfg          (r_cfg),
        .i_state        (r_state),
        .i_cmd          (s_axis_tuser),
        .i_outside_temp (s_axis_tdata[11:0]),
        .i_inside_temp  (s_axis_tdata[23:12]),
        .i_now_ms       (s_axis_tdata[55:24]),
        .o_state        (n_state)
    );

    // result packing from the state after this beat
    always_comb begin
        n_m_data        = '0;
        n_m_data[0]     = n_state.fan;
        n_m_data[1]     = n_state.phase[VENT_LEFT]   == PH_OPEN;
        n_m_data[2]     = n_state.phase[VENT_LEFT]   == PH_CLOSE;
        n_m_data[3]     = n_state.phase[VENT_RIGHT]  == PH_OPEN;
        n_m_data[4]     = n_state.phase[VENT_RIGHT]  == PH_CLOSE;
        n_m_data[5]     = n_state.phase[VENT_INTAKE] == PH_OPEN;
        n_m_data[6]     = n_state.phase[VENT_INTAKE] == PH_CLOSE;
        n_m_data[10:7]  = n_state.step;
        n_m_data[11]    = n_state.power;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint      <= 12'sd64;
            r_cfg.inside_delta  <= 10'd16;
            r_cfg.outside_delta <= 10'd16;
            r_cfg.frost_limit   <= 12'sd0;
            r_cfg.frost_delta   <= 10'd16;
            r_cfg.travel_ms     <= 20'd30000;
            r_cfg.auto_mode     <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SETPOINT:      r_cfg.setpoint      <= i_cfg_data[11:0];
                CFG_INSIDE_DELTA:  r_cfg.inside_delta  <= i_cfg_data[9:0];
                CFG_OUTSIDE_DELTA: r_cfg.outside_delta <= i_cfg_data[9:0];
                CFG_FROST_LIMIT:   r_cfg.frost_limit   <= i_cfg_data[11:0];
                CFG_FROST_DELTA:   r_cfg.frost_delta   <= i_cfg_data[9:0];
                CFG_TRAVEL_TIME:   r_cfg.travel_ms     <= i_cfg_data[19:0];
                CFG_AUTO_MODE:     r_cfg.auto_mode     <= i_cfg_data[0];
                default: begin
                    // index past the list, write dropped
                end
            endcase
        end
    end

    // sequencer state, advanced once per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.step     <= STEP_IDLE;
            r_state.power    <= 1'b1;
            r_state.fan      <= 1'b0;
            r_state.phase    <= {PH_STOP, PH_STOP, PH_STOP};
            r_state.start_ms <= '0;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_accept) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_data <= n_m_data;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

`default_nettype wire

// ===== hdl/vss_checker.sv =====
`default_nettype none

module vss_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);
    import vss_pkg::*;

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed under stall");

    // input side is free exactly when the result slot can take a beat
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow result slot");

    // every taken beat yields a result in the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("no result after accepted beat");

    // step code never leaves the defined range
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[10:7] <= STEP_CLOSED_WAIT)
        else $error("sequence step out of range");

    // fan only runs in the fan steps
    a_fan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |->
            (m_axis_tdata[10:7] == STEP_FAN_RUN) || (m_axis_tdata[10:7] == STEP_FAN_STOP))
        else $error("fan on outside fan steps");

endmodule

bind ventilation_section_sequencer vss_checker u_vss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
